// ----- hw/rtl/epm_pkg.sv -----
package epm_pkg;

	localparam int PATTERN_MAX   = 64;
	localparam int POSITION_BITS = 16;
	localparam int LEN_BITS      = $clog2(PATTERN_MAX + 1);
	localparam int CHAR_BITS     = 8;
	localparam int KIND_BITS     = 2;
	localparam int START_BITS    = 16;

	localparam logic [CHAR_BITS-1:0]     SEPARATOR = 8'h24;
	localparam logic [POSITION_BITS-1:0] POS_ALL_ONES = '1;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_PATTERN = 2'd0,
		KIND_TEXT    = 2'd1,
		KIND_RESTART = 2'd2
	} epm_kind_t;

	typedef logic [PATTERN_MAX-1:0][CHAR_BITS-1:0] epm_bytes_t;

	// state update strobes from the top level to the pattern and window units
	typedef struct packed {
		logic                 pattern_push;
		logic                 text_push;
		logic                 restart;
		logic [CHAR_BITS-1:0] ch;
	} epm_ctl_t;

endpackage

// ----- hw/rtl/epm_in_if.sv -----
interface epm_in_if;
	logic                              valid;
	logic                              ready;
	logic [epm_pkg::KIND_BITS-1:0]     kind;
	logic [epm_pkg::CHAR_BITS-1:0]     char_value;

	modport source (output valid, output kind, output char_value, input ready);
	modport sink (input valid, input kind, input char_value, output ready);
endinterface

// ----- hw/rtl/epm_out_if.sv -----
interface epm_out_if;
	logic                              valid;
	logic                              ready;
	logic [epm_pkg::START_BITS-1:0]    match_start;
	logic                              position_overflow;

	modport source (output valid, output match_start, output position_overflow, input ready);
	modport sink (input valid, input match_start, input position_overflow, output ready);
endinterface

// ----- hw/rtl/epm_pattern.sv -----
module epm_pattern (
	input  logic                          clk,
	input  logic                          arst_n,
	input  epm_pkg::epm_ctl_t             ctl,
	output epm_pkg::epm_bytes_t           pat,
	output logic [epm_pkg::PATTERN_MAX-1:0] mask,
	output logic [epm_pkg::LEN_BITS-1:0]  len
);

	// pattern kept newest byte first, so entry j lines up with window entry j
	epm_pkg::epm_bytes_t                 pat_q;
	logic [epm_pkg::PATTERN_MAX-1:0]     mask_q;
	logic [epm_pkg::LEN_BITS-1:0]        len_q;
	logic                                room;

	assign room = len_q < epm_pkg::LEN_BITS'(epm_pkg::PATTERN_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			mask_q <= '0;
		end else if (ctl.restart) begin
			len_q  <= '0;
			mask_q <= '0;
		end else if (ctl.pattern_push && room) begin
			len_q  <= len_q + 1'b1;
			mask_q <= {mask_q[epm_pkg::PATTERN_MAX-2:0], 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pattern_push && room) begin
			pat_q <= {pat_q[epm_pkg::PATTERN_MAX-2:0], ctl.ch};
		end
	end

	assign pat  = pat_q;
	assign mask = mask_q;
	assign len  = len_q;

endmodule

// ----- hw/rtl/epm_window.sv -----
module epm_window (
	input  logic                            clk,
	input  logic                            arst_n,
	input  epm_pkg::epm_ctl_t               ctl,
	input  epm_pkg::epm_bytes_t             pat,
	input  logic [epm_pkg::PATTERN_MAX-1:0] mask,
	output logic                            hit
);

	epm_pkg::epm_bytes_t             win_q;
	epm_pkg::epm_bytes_t             win_next;
	logic [epm_pkg::PATTERN_MAX-1:0] ok;

	// compare runs on the window with the incoming text byte already in place
	assign win_next = {win_q[epm_pkg::PATTERN_MAX-2:0], ctl.ch};

	always_comb begin
		for (int j = 0; j < epm_pkg::PATTERN_MAX; j++) begin
			ok[j] = !mask[j] ||
				(pat[j] == win_next[j] && pat[j] != epm_pkg::SEPARATOR &&
				 win_next[j] != epm_pkg::SEPARATOR);
		end
	end

	assign hit = &ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctl.restart) begin
			win_q <= '0;
		end else if (ctl.text_push) begin
			win_q <= win_next;
		end
	end

endmodule

// ----- hw/rtl/exact_pattern_matcher.sv -----
// Streaming exact string matcher. Send pattern bytes (kind 0), then text bytes
// (kind 1); a restart (kind 2) clears the pattern, text offset and window. For
// each text byte that completes an occurrence of the pattern, one result gives
// the zero-based start offset of that occurrence, so starts leave in ascending
// order; an empty pattern reports every text offset, else a '$' byte never matches.
// Pattern bytes past 64 are dropped. The offset counter saturates at all ones
// and then sets position_overflow, with match_start held at all ones until a
// restart. One request is taken per clock while the result side keeps up: a
// request is held in the input register, the 64-byte window compare sits
// between that register and the result register, and a result held back by
// the receiver holds the request in the input register.
module exact_pattern_matcher (
	input  logic      clk,
	input  logic      arst_n,
	epm_in_if.sink    in,
	epm_out_if.source out
);

	localparam int PB = epm_pkg::POSITION_BITS;

	logic                               valid_s1;
	logic [epm_pkg::KIND_BITS-1:0]      kind_s1;
	logic [epm_pkg::CHAR_BITS-1:0]      char_s1;

	logic                               out_valid_q;
	logic [epm_pkg::START_BITS-1:0]     match_start_q;
	logic                               overflow_out_q;

	logic [PB-1:0]                      pos_q;
	logic                               ovf_q;

	logic                               advance;
	logic                               fire;
	epm_pkg::epm_ctl_t                  ctl;
	epm_pkg::epm_bytes_t                pat;
	logic [epm_pkg::PATTERN_MAX-1:0]    mask;
	logic [epm_pkg::LEN_BITS-1:0]       len;
	logic                               win_hit;

	logic                               ovf_next;
	logic [PB-1:0]                      pos_next;
	logic [PB:0]                        end_count;
	logic [PB:0]                        start_wide;
	logic [PB-1:0]                      start;
	logic                               hit;

	assign advance  = !out_valid_q || out.ready;
	assign fire     = valid_s1 && advance;
	assign in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.valid && in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			kind_s1 <= in.kind;
			char_s1 <= in.char_value;
		end
	end

	always_comb begin
		ctl              = '0;
		ctl.ch           = char_s1;
		unique case (epm_pkg::epm_kind_t'(kind_s1))
			epm_pkg::KIND_PATTERN: ctl.pattern_push = fire;
			epm_pkg::KIND_TEXT:    ctl.text_push    = fire;
			epm_pkg::KIND_RESTART: ctl.restart      = fire;
			default:               ctl              = '{default: '0};
		endcase
	end

	epm_pattern u_pattern (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pat    (pat),
		.mask   (mask),
		.len    (len)
	);

	epm_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pat    (pat),
		.mask   (mask),
		.hit    (win_hit)
	);

	// offset bookkeeping for the text byte in the input register
	assign ovf_next   = ovf_q || (pos_q == epm_pkg::POS_ALL_ONES);
	assign pos_next   = ovf_next ? epm_pkg::POS_ALL_ONES : pos_q + 1'b1;
	assign end_count  = {1'b0, pos_q} + 1'b1;
	assign start_wide = end_count - (PB + 1)'(len);

	always_comb begin
		if (ovf_next) begin
			start = epm_pkg::POS_ALL_ONES;
		end else if (len == '0) begin
			start = pos_q;
		end else begin
			start = start_wide[PB-1:0];
		end
	end

	assign hit = (len == '0) ||
		((ovf_next || end_count >= (PB + 1)'(len)) && win_hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctl.restart) begin
			pos_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctl.text_push) begin
			pos_q <= pos_next;
			ovf_q <= ovf_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= ctl.text_push && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.text_push && hit) begin
			match_start_q  <= epm_pkg::START_BITS'(start);
			overflow_out_q <= ovf_next;
		end
	end

	assign out.valid             = out_valid_q;
	assign out.match_start       = match_start_q;
	assign out.position_overflow = overflow_out_q;

	a_ovf_start_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.position_overflow |->
			out.match_start == epm_pkg::START_BITS'(epm_pkg::POS_ALL_ONES))
		else $error("overflowed result without saturated start");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.restart |=> pos_q == '0 && !ovf_q && len == '0)
		else $error("restart left offset or pattern state");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in.ready |-> valid_s1 && out_valid_q && !out.ready)
		else $error("input stalled without a blocked result");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len <= epm_pkg::LEN_BITS'(epm_pkg::PATTERN_MAX))
		else $error("pattern length past capacity");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

	localparam logic [epm_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;
	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_ITEMS = 1700;

	typedef struct packed {
		logic [epm_pkg::START_BITS-1:0] start;
		logic                           overflow;
	} match_t;

	// one request; typed rows carry a hand-written expectation
	typedef struct packed {
		logic [epm_pkg::KIND_BITS-1:0] kind;
		logic [epm_pkg::CHAR_BITS-1:0] ch;
		logic                          typed;
		logic                          hit;
		match_t                        res;
	} req_t;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_RANDOM,
		RX_PERIODIC,
		RX_HOLD
	} rx_mode_t;

	localparam req_t DIRECTED [26] = '{
		'{epm_pkg::KIND_TEXT,    "a",                1'b1, 1'b1, '{16'd0, 1'b0}},
		'{epm_pkg::KIND_TEXT,    8'hFF,              1'b1, 1'b1, '{16'd1, 1'b0}},
		'{epm_pkg::KIND_TEXT,    epm_pkg::SEPARATOR, 1'b1, 1'b1, '{16'd2, 1'b0}},
		'{KIND_UNUSED,           8'hFF,              1'b1, 1'b0, '0},
		'{epm_pkg::KIND_RESTART, 8'h00,              1'b1, 1'b0, '0},
		'{epm_pkg::KIND_PATTERN, "a",                1'b1, 1'b0, '0},
		'{epm_pkg::KIND_PATTERN, "b",                1'b1, 1'b0, '0},
		'{epm_pkg::KIND_PATTERN, "a",                1'b1, 1'b0, '0},
		'{epm_pkg::KIND_TEXT,    "a",                1'b0, 1'b0, '0},
		'{epm_pkg::KIND_TEXT,    "b",                1'b0, 1'b0, '0},
		'{epm_pkg::KIND_TEXT,    "a",                1'b0, 1'b0, '0},
		'{epm_pkg::KIND_TEXT,    "b",                1'b0, 1'b0, '0},
		'{epm_pkg::KIND_TEXT,    "a",                1'b0, 1'b0, '0},
		'{epm_pkg::KIND_PATTERN, "b",                1'b1, 1'b0, '0},
		'{epm_pkg::KIND_TEXT,    "b",                1'b0, 1'b0, '0},
		'{epm_pkg::KIND_RESTART, 8'hFF,              1'b1, 1'b0, '0},
		'{epm_pkg::KIND_PATTERN, epm_pkg::SEPARATOR, 1'b1, 1'b0, '0},
		'{epm_pkg::KIND_TEXT,    epm_pkg::SEPARATOR, 1'b0, 1'b0, '0},
		'{epm_pkg::KIND_RESTART, 8'h00,              1'b1, 1'b0, '0},
		'{epm_pkg::KIND_PATTERN, 8'h00,              1'b1, 1'b0, '0},
		'{epm_pkg::KIND_TEXT,    8'h00,              1'b0, 1'b0, '0},
		'{epm_pkg::KIND_PATTERN, 8'hFF,              1'b1, 1'b0, '0},
		'{epm_pkg::KIND_TEXT,    8'hFF,              1'b0, 1'b0, '0},
		'{epm_pkg::KIND_RESTART, 8'h00,              1'b1, 1'b0, '0},
		'{epm_pkg::KIND_PATTERN, "x",                1'b1, 1'b0, '0},
		'{epm_pkg::KIND_TEXT,    epm_pkg::SEPARATOR, 1'b0, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	epm_in_if  in_bus ();
	epm_out_if out_bus ();

	exact_pattern_matcher uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_bus),
		.out    (out_bus)
	);

	always #5 clk = ~clk;

	// matcher state as seen by the scoreboard
	logic [epm_pkg::CHAR_BITS-1:0]     pat_bytes [epm_pkg::PATTERN_MAX];
	logic [epm_pkg::LEN_BITS-1:0]      pat_len;
	logic [epm_pkg::CHAR_BITS-1:0]     text_win [epm_pkg::PATTERN_MAX];
	logic [epm_pkg::POSITION_BITS-1:0] text_pos;
	logic                              pos_saturated;

	match_t expected_matches [$];
	match_t want;
	match_t predicted;
	logic   predicted_hit;
	req_t   cur_req;
	int     errors = 0;
	int     burst_left = 0;
	int     sent_items = 0;
	int     idle_cycles = 0;

	function automatic logic predict_match(input logic [epm_pkg::KIND_BITS-1:0] kind,
			input logic [epm_pkg::CHAR_BITS-1:0] ch, output match_t res);
		logic [epm_pkg::POSITION_BITS-1:0] offset;
		logic [epm_pkg::POSITION_BITS-1:0] start;
		logic                              hit;
		res = '0;
		case (kind)
			epm_pkg::KIND_PATTERN: begin
				if (pat_len < epm_pkg::PATTERN_MAX) begin
					pat_bytes[pat_len[$clog2(epm_pkg::PATTERN_MAX)-1:0]] = ch;
					pat_len++;
				end
				return 1'b0;
			end
			epm_pkg::KIND_RESTART: begin
				foreach (text_win[i])
					text_win[i] = '0;
				pat_len = '0;
				text_pos = '0;
				pos_saturated = 1'b0;
				return 1'b0;
			end
			epm_pkg::KIND_TEXT: begin
				for (int j = epm_pkg::PATTERN_MAX - 1; j > 0; j--)
					text_win[j] = text_win[j-1];
				text_win[0] = ch;
				offset = text_pos;
				if (pos_saturated || offset == epm_pkg::POS_ALL_ONES) begin
					pos_saturated = 1'b1;
					text_pos = epm_pkg::POS_ALL_ONES;
				end else begin
					text_pos = offset + 1'b1;
				end
				hit = 1'b1;
				if (pat_len == 0) begin
					start = pos_saturated ? epm_pkg::POS_ALL_ONES : offset;
				end else begin
					if (!pos_saturated && int'(offset) + 1 < int'(pat_len))
						hit = 1'b0;
					// window holds newest byte first, so compare against the pattern tail
					for (int j = 0; j < int'(pat_len); j++) begin
						if (pat_bytes[int'(pat_len) - 1 - j] == epm_pkg::SEPARATOR
								|| text_win[j] == epm_pkg::SEPARATOR
								|| pat_bytes[int'(pat_len) - 1 - j] != text_win[j])
							hit = 1'b0;
					end
					start = pos_saturated ? epm_pkg::POS_ALL_ONES : offset + 1'b1 - pat_len;
				end
				res.start = start[epm_pkg::START_BITS-1:0];
				res.overflow = pos_saturated;
				return hit;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	function automatic logic [epm_pkg::CHAR_BITS-1:0] pick_byte(input int alpha);
		if (alpha < 4)
			return $urandom_range(0, 1) ? "a" : "b";
		if (alpha < 7)
			return ($urandom_range(0, 15) == 0) ? epm_pkg::SEPARATOR :
				8'("a" + $urandom_range(0, 2));
		if (alpha < 9)
			return 8'($urandom);
		return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
	endfunction

	task automatic issue(input req_t r);
		@(negedge clk);
		if (burst_left == 0) begin
			in_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
		end
		burst_left--;
		cur_req = r;
		in_bus.valid <= 1'b1;
		in_bus.kind <= r.kind;
		in_bus.char_value <= r.ch;
		do
			@(posedge clk);
		while (!in_bus.ready);
		if (r.kind != KIND_UNUSED)
			sent_items++;
	endtask

	task automatic send(input logic [epm_pkg::KIND_BITS-1:0] kind,
			input logic [epm_pkg::CHAR_BITS-1:0] ch);
		req_t r;
		r = '0;
		r.kind = kind;
		r.ch = ch;
		issue(r);
	endtask

	// hold off new requests until every predicted match has come back
	task automatic drain_matches();
		@(negedge clk);
		in_bus.valid <= 1'b0;
		burst_left = 0;
		while (expected_matches.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_sequences(input int quota);
		logic [epm_pkg::CHAR_BITS-1:0] seq_pattern [$];
		logic [epm_pkg::CHAR_BITS-1:0] c;
		int alpha, pick, plen, tlen, cut, stop_at;
		stop_at = sent_items + quota;
		while (sent_items < stop_at) begin
			if ($urandom_range(0, 9) != 0) begin
				send(epm_pkg::KIND_RESTART, 8'($urandom));
				seq_pattern.delete();
			end
			alpha = $urandom_range(0, 9);
			pick = $urandom_range(0, 19);
			plen = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(60, 70) :
				(pick < 14) ? $urandom_range(1, 4) : $urandom_range(5, 12);
			repeat (plen) begin
				c = pick_byte(alpha);
				send(epm_pkg::KIND_PATTERN, c);
				if (seq_pattern.size() < epm_pkg::PATTERN_MAX)
					seq_pattern = {seq_pattern, c};
			end
			tlen = (plen > 20) ? $urandom_range(70, 140) : $urandom_range(8, 48);
			for (int t = 0; t < tlen; t++) begin
				if (seq_pattern.size() != 0 && $urandom_range(0, 4) == 0) begin
					// planted occurrence, sometimes with one byte spoiled
					cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, seq_pattern.size() - 1) : -1;
					foreach (seq_pattern[i])
						send(epm_pkg::KIND_TEXT, (i == cut) ? pick_byte(alpha) : seq_pattern[i]);
				end else begin
					send(epm_pkg::KIND_TEXT, pick_byte(alpha));
				end
				if ($urandom_range(0, 29) == 0)
					send(KIND_UNUSED, 8'($urandom));
				if ($urandom_range(0, 49) == 0) begin
					c = pick_byte(alpha);
					send(epm_pkg::KIND_PATTERN, c);
					if (seq_pattern.size() < epm_pkg::PATTERN_MAX)
						seq_pattern = {seq_pattern, c};
				end
			end
			if ($urandom_range(0, 5) == 0)
				drain_matches();
		end
	endtask

	always @(posedge clk) begin
		if (out_bus.valid && out_bus.ready) begin
			if (expected_matches.size() == 0) begin
				errors++;
				$display("%0t: expected no result, got match_start %0d position_overflow %b",
					$time, out_bus.match_start, out_bus.position_overflow);
			end else begin
				want = expected_matches.pop_front();
				if (want.start !== out_bus.match_start) begin
					errors++;
					$display("%0t: match_start expected %0d got %0d",
						$time, want.start, out_bus.match_start);
				end
				if (want.overflow !== out_bus.position_overflow) begin
					errors++;
					$display("%0t: position_overflow expected %b got %b",
						$time, want.overflow, out_bus.position_overflow);
				end
			end
		end
		if (in_bus.valid && in_bus.ready) begin
			predicted_hit = predict_match(in_bus.kind, in_bus.char_value, predicted);
			if (cur_req.typed) begin
				predicted_hit = cur_req.hit;
				predicted = cur_req.res;
			end
			if (predicted_hit)
				expected_matches = {expected_matches, predicted};
		end
	end

	always @(negedge clk) begin : rx_stall
		rx_mode_t mode;
		int left;
		int count;
		if (left == 0) begin
			mode = rx_mode_t'($urandom_range(0, 3));
			left = (mode == RX_HOLD) ? $urandom_range(2, 30) : $urandom_range(5, 60);
		end
		left--;
		count++;
		case (mode)
			RX_STEADY:   out_bus.ready <= 1'b1;
			RX_RANDOM:   out_bus.ready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: out_bus.ready <= (count % 4) != 0;
			default:     out_bus.ready <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		in_bus.valid = 1'b0;
		in_bus.kind = epm_pkg::KIND_PATTERN;
		in_bus.char_value = '0;
		out_bus.ready = 1'b0;
		cur_req = '0;
		foreach (text_win[i])
			text_win[i] = '0;
		foreach (pat_bytes[i])
			pat_bytes[i] = '0;
		pat_len = '0;
		text_pos = '0;
		pos_saturated = 1'b0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i])
			issue(DIRECTED[i]);
		drain_matches();

		run_sequences(RANDOM_ITEMS / 2);
		drain_matches();

		run_sequences(RANDOM_ITEMS - RANDOM_ITEMS / 2);
		drain_matches();

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
